// ----- src/sla_pkg.sv -----
// Shared types and constants for the serial line assembler.
// Used by every module of the block but sla_ram; depends on nothing.
package sla_pkg;

    localparam int LINE_DEPTH_DEF = 64;

    localparam int BYTE_W   = 8;
    localparam int FUNC_W   = 2;
    localparam int INDEX_W  = 6;
    localparam int LENGTH_W = 7;
    // wide enough for any count or index up to the largest line store
    localparam int WIDE_W   = 9;

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 32;

    localparam int CFG_ADDR_W = 1;

    localparam logic [BYTE_W-1:0] END_CHAR_RESET  = 8'h0d;
    localparam logic [BYTE_W-1:0] SKIP_CHAR_RESET = 8'h0a;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_END_CHAR  = 1'b0,
        CFG_SKIP_CHAR = 1'b1
    } cfg_reg_t;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_RX_BYTE = 2'd0,
        FUNC_RELEASE = 2'd1,
        FUNC_CLEAR   = 2'd2,
        FUNC_READ    = 2'd3
    } func_t;

    // state seen after one request, handed from control to the output pipe
    typedef struct packed {
        logic                line_done;
        logic [LENGTH_W-1:0] line_length;
        logic [BYTE_W-1:0]   error_count;
        logic                line_event;
        logic                accepting;
        logic                read_hit;
    } status_t;

endpackage

// ----- src/sla_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module sla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/sla_ctrl.sv -----
// Line assembly control: configuration registers, counters and flags, and the
// write and read requests to the line store. Depends on sla_pkg.
module sla_ctrl #(
    parameter int LINE_DEPTH = sla_pkg::LINE_DEPTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [sla_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [sla_pkg::BYTE_W-1:0]        cfg_wdata,
    input  logic                              fire,
    input  sla_pkg::func_t                    func,
    input  logic [sla_pkg::BYTE_W-1:0]        rx_byte,
    input  logic                              rx_error,
    input  logic [sla_pkg::INDEX_W-1:0]       read_index,
    output logic                              ram_we,
    output logic [$clog2(LINE_DEPTH)-1:0]     ram_waddr,
    output logic [sla_pkg::BYTE_W-1:0]        ram_wdata,
    output logic                              ram_re,
    output logic [$clog2(LINE_DEPTH)-1:0]     ram_raddr,
    output sla_pkg::status_t                  status
);

    localparam int AW = $clog2(LINE_DEPTH);
    localparam int CW = $clog2(LINE_DEPTH + 1);

    logic [sla_pkg::BYTE_W-1:0] end_char_reg;
    logic [sla_pkg::BYTE_W-1:0] skip_char_reg;

    logic [CW-1:0]              count_reg, count_next;
    logic                       accept_reg, accept_next;
    logic [sla_pkg::BYTE_W-1:0] reject_reg, reject_next;
    logic                       event_reg, event_next;
    logic                       done;
    logic                       room;
    logic [sla_pkg::WIDE_W-1:0] index_wide;
    logic [sla_pkg::WIDE_W-1:0] count_wide;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            end_char_reg  <= sla_pkg::END_CHAR_RESET;
            skip_char_reg <= sla_pkg::SKIP_CHAR_RESET;
        end else if (cfg_we) begin
            unique case (sla_pkg::cfg_reg_t'(cfg_addr))
                sla_pkg::CFG_END_CHAR:  end_char_reg  <= cfg_wdata;
                sla_pkg::CFG_SKIP_CHAR: skip_char_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign room       = (accept_reg && reject_reg == '0 && count_reg < CW'(LINE_DEPTH));
    assign index_wide = sla_pkg::WIDE_W'(read_index);

    always_comb begin
        count_next  = count_reg;
        accept_next = accept_reg;
        reject_next = reject_reg;
        event_next  = event_reg;
        done        = 1'b0;
        ram_we      = 1'b0;
        ram_wdata   = rx_byte;
        ram_re      = 1'b0;
        if (fire) begin
            unique case (func)
                sla_pkg::FUNC_RX_BYTE: begin
                    // drop flagged bytes and the skip character
                    if (!rx_error && rx_byte != skip_char_reg) begin
                        if (room) begin
                            ram_we = 1'b1;
                            if (rx_byte == end_char_reg) begin
                                ram_wdata   = '0;
                                accept_next = 1'b0;
                                done        = 1'b1;
                                event_next  = 1'b1;
                            end else begin
                                count_next = count_reg + CW'(1);
                            end
                        end else begin
                            count_next = '0;
                            if (rx_byte == end_char_reg) begin
                                reject_next = '0;
                                accept_next = 1'b1;
                            end else begin
                                reject_next = reject_reg + 8'd1;
                            end
                        end
                    end
                end
                sla_pkg::FUNC_RELEASE: begin
                    count_next  = '0;
                    accept_next = 1'b1;
                end
                sla_pkg::FUNC_CLEAR: begin
                    event_next = 1'b0;
                end
                sla_pkg::FUNC_READ: begin
                    ram_re = 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            accept_reg <= 1'b1;
            reject_reg <= '0;
            event_reg  <= 1'b0;
        end else begin
            count_reg  <= count_next;
            accept_reg <= accept_next;
            reject_reg <= reject_next;
            event_reg  <= event_next;
        end
    end

    assign ram_waddr  = count_reg[AW-1:0];
    assign ram_raddr  = index_wide[AW-1:0];
    assign count_wide = sla_pkg::WIDE_W'(count_next);

    always_comb begin
        status.line_done   = done;
        status.line_length = count_wide[sla_pkg::LENGTH_W-1:0];
        status.error_count = reject_next;
        status.line_event  = event_next;
        status.accepting   = accept_next;
        // an index past the store reads as zero
        status.read_hit    = (func == sla_pkg::FUNC_READ) &&
                             (index_wide < sla_pkg::WIDE_W'(LINE_DEPTH));
    end

endmodule

// ----- src/serial_line_assembler_top.sv -----
// Top level of the serial line assembler: request pipe, line store and result
// register. Depends on sla_pkg, sla_ctrl and sla_ram.
//
//  Channel  Ports                         Contents (low bit first)
//  -------  ----------------------------  ---------------------------------------------
//  input    s_tvalid s_tready s_tdata     rx_byte, rx_error, read_index, zero fill
//           s_tuser                       func
//  result   m_tvalid m_tready m_tdata     line_length, error_count, line_event,
//           m_tlast                       accepting, read_data, zero fill; line_done
//  config   cfg_we cfg_addr cfg_wdata     0 end_char, 1 skip_char
//
// One request per cycle while s_tready is high; each result passes the pipe
// stage, which covers the registered read of the line store, then the result register.
// State and flags update at the accepting edge, so back-to-back requests see
// each other's effects at once.
// A stalled result holds both pipe stages; s_tready drops only when both are full.
// Reset is synchronous: counters, flags and config return to their reset values;
// line store contents are not cleared.
module serial_line_assembler_top #(
    parameter int LINE_DEPTH = sla_pkg::LINE_DEPTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [sla_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [sla_pkg::BYTE_W-1:0]       cfg_wdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [sla_pkg::S_TDATA_W-1:0]    s_tdata,  // rx_byte[7:0] rx_error[8] read_index[14:9]
    input  logic [sla_pkg::FUNC_W-1:0]       s_tuser,  // func[1:0]
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // line_length[6:0] error_count[14:7] line_event[15] accepting[16] read_data[24:17]
    output logic [sla_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                             m_tlast   // line_done
);

    localparam int AW = $clog2(LINE_DEPTH);

    logic                       fire;
    logic                       pipe_adv;
    logic                       out_free;
    logic                       ram_we;
    logic [AW-1:0]              ram_waddr;
    logic [sla_pkg::BYTE_W-1:0] ram_wdata;
    logic                       ram_re;
    logic [AW-1:0]              ram_raddr;
    logic [sla_pkg::BYTE_W-1:0] ram_rdata;
    logic [sla_pkg::BYTE_W-1:0] read_data;
    sla_pkg::status_t           status;

    logic                         pipe_valid_reg;
    sla_pkg::status_t             pipe_status_reg;
    logic                         out_valid_reg;
    logic [sla_pkg::M_TDATA_W-1:0] out_data_reg, out_data_next;
    logic                         out_last_reg;

    assign out_free = !out_valid_reg || m_tready;
    assign pipe_adv = pipe_valid_reg && out_free;
    assign s_tready = !pipe_valid_reg || out_free;
    assign fire     = s_tvalid && s_tready;

    sla_ctrl #(
        .LINE_DEPTH(LINE_DEPTH)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .fire       (fire),
        .func       (sla_pkg::func_t'(s_tuser)),
        .rx_byte    (s_tdata[7:0]),
        .rx_error   (s_tdata[8]),
        .read_index (s_tdata[14:9]),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .ram_re     (ram_re),
        .ram_raddr  (ram_raddr),
        .status     (status)
    );

    sla_ram #(
        .WIDTH(sla_pkg::BYTE_W),
        .DEPTH(LINE_DEPTH)
    ) u_line_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // pipe stage: hold status while the store read completes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pipe_valid_reg <= 1'b0;
        end else if (s_tready) begin
            pipe_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            pipe_status_reg <= status;
        end
    end

    assign read_data = pipe_status_reg.read_hit ? ram_rdata : '0;

    always_comb begin
        out_data_next        = '0;
        out_data_next[6:0]   = pipe_status_reg.line_length;
        out_data_next[14:7]  = pipe_status_reg.error_count;
        out_data_next[15]    = pipe_status_reg.line_event;
        out_data_next[16]    = pipe_status_reg.accepting;
        out_data_next[24:17] = read_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= pipe_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_adv) begin
            out_data_reg <= out_data_next;
            out_last_reg <= pipe_status_reg.line_done;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ----- src/sla_checker.sv -----
// Port-level checks for the serial line assembler, bound to the top level.
// Depends on sla_pkg and serial_line_assembler_top.
module sla_checker #(
    parameter int LINE_DEPTH = sla_pkg::LINE_DEPTH_DEF
) (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [sla_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic                           m_tlast
);

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // a completed line leaves the event set and accepting cleared
    a_done_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata[15] && !m_tdata[16])
        else $error("line done without event set or with accepting high");

    // a completed line comes from a received byte, never from a store read
    a_done_no_read: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata[24:17] == 8'd0)
        else $error("line done carries read data");

    // line length never exceeds the store (checked for store depths up to 127)
    a_length: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (LINE_DEPTH > 127) || (32'(m_tdata[6:0]) <= LINE_DEPTH))
        else $error("line length beyond store depth");

    // no result without an accepted request: empty after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("pipe not empty after reset");

endmodule

bind serial_line_assembler_top sla_checker #(
    .LINE_DEPTH(LINE_DEPTH)
) u_sla_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// ----- dv/sla_line_checker.sv -----
`timescale 1ns / 100ps
// Line checker for the serial line assembler: watches the request, result and
// register ports, predicts every result and compares it field by field.
// Depends on sla_pkg only.
module sla_line_checker #(
    parameter int DEPTH = sla_pkg::LINE_DEPTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [sla_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [sla_pkg::BYTE_W-1:0]     cfg_wdata,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [sla_pkg::S_TDATA_W-1:0]  s_tdata,  // rx_byte[7:0] rx_error[8] read_index[14:9]
    input  logic [sla_pkg::FUNC_W-1:0]     s_tuser,  // func[1:0]
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    // line_length[6:0] error_count[14:7] line_event[15] accepting[16] read_data[24:17]
    input  logic [sla_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic                           m_tlast,  // line_done
    output int                             pending,
    output logic [DEPTH-1:0]               written,
    output int                             fail_count
);
    import sla_pkg::*;

    typedef struct packed {
        logic                line_done;
        logic [LENGTH_W-1:0] line_length;
        logic [BYTE_W-1:0]   error_count;
        logic                line_event;
        logic                accepting;
        logic [BYTE_W-1:0]   read_data;
    } line_status_t;

    logic [BYTE_W-1:0] line_mem [DEPTH];
    logic [DEPTH-1:0]  seen_mask = '0;
    int unsigned       stored;
    logic              armed;
    logic [BYTE_W-1:0] rejects;
    logic              event_seen;
    logic [BYTE_W-1:0] end_c;
    logic [BYTE_W-1:0] skip_c;
    line_status_t      expected_status_q [$];
    int                mismatches = 0;

    assign fail_count = mismatches;

    task automatic note_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
        $display("%0t ns  %s: got %0h, expected %0h", $time, what, got, want);
        mismatches++;
    endtask

    task automatic compare_field(input string name, input logic [7:0] got,
                                 input logic [7:0] want);
        if (got !== want)
            note_mismatch(name, got, want);
    endtask

    // Apply one request to the predicted line state; return the status it shows.
    function automatic line_status_t advance_line_state(input func_t f, input logic [7:0] c,
                                                        input logic err,
                                                        input logic [INDEX_W-1:0] idx);
        line_status_t st;
        st = '0;
        case (f)
            FUNC_RX_BYTE: begin
                if (!err && c != skip_c) begin
                    if (armed && rejects == 8'd0 && stored < DEPTH) begin
                        if (c == end_c) begin
                            // terminate in place, do not count the terminator
                            line_mem[stored]  = 8'h00;
                            seen_mask[stored] = 1'b1;
                            armed             = 1'b0;
                            st.line_done      = 1'b1;
                            event_seen        = 1'b1;
                        end else begin
                            line_mem[stored]  = c;
                            seen_mask[stored] = 1'b1;
                            stored++;
                        end
                    end else begin
                        rejects = rejects + 8'd1;
                        stored  = 0;
                        if (c == end_c) begin
                            rejects = 8'd0;
                            armed   = 1'b1;
                        end
                    end
                end
            end
            FUNC_RELEASE: begin
                stored = 0;
                armed  = 1'b1;
            end
            FUNC_CLEAR: event_seen = 1'b0;
            default: begin
                if (idx < DEPTH)
                    st.read_data = line_mem[idx];
            end
        endcase
        st.line_length = stored[LENGTH_W-1:0];
        st.error_count = rejects;
        st.line_event  = event_seen;
        st.accepting   = armed;
        return st;
    endfunction

    always @(posedge aclk) begin
        line_status_t got;
        line_status_t want;
        if (!aresetn) begin
            stored     = 0;
            armed      = 1'b1;
            rejects    = 8'd0;
            event_seen = 1'b0;
            end_c      = END_CHAR_RESET;
            skip_c     = SKIP_CHAR_RESET;
            expected_status_q.delete();
        end else begin
            if (cfg_we) begin
                if (cfg_addr == CFG_END_CHAR)
                    end_c = cfg_wdata;
                else
                    skip_c = cfg_wdata;
            end
            if (s_tvalid && s_tready)
                expected_status_q.push_back(advance_line_state(func_t'(s_tuser), s_tdata[7:0],
                                                               s_tdata[8], s_tdata[14:9]));
            if (m_tvalid && m_tready) begin
                got.line_done   = m_tlast;
                got.line_length = m_tdata[6:0];
                got.error_count = m_tdata[14:7];
                got.line_event  = m_tdata[15];
                got.accepting   = m_tdata[16];
                got.read_data   = m_tdata[24:17];
                if (expected_status_q.size() == 0) begin
                    note_mismatch("result with no request waiting, line_length",
                                  {1'b0, got.line_length}, 8'h00);
                end else begin
                    want = expected_status_q.pop_front();
                    compare_field("line_done", 8'(got.line_done), 8'(want.line_done));
                    compare_field("line_length", 8'(got.line_length),
                                  8'(want.line_length));
                    compare_field("error_count", got.error_count, want.error_count);
                    compare_field("line_event", 8'(got.line_event), 8'(want.line_event));
                    compare_field("accepting", 8'(got.accepting), 8'(want.accepting));
                    compare_field("read_data", got.read_data, want.read_data);
                end
            end
        end
        pending <= expected_status_q.size();
        written <= seen_mask;
    end

endmodule

// ----- dv/serial_line_assembler_top_test.sv -----
`timescale 1ns / 100ps
// Test top for the serial line assembler: clock, reset, register setup and
// request/receive traffic, plus the final verdict.
// Depends on sla_pkg, serial_line_assembler_top and sla_line_checker.
module serial_line_assembler_top_test;
    import sla_pkg::*;

    localparam int DEPTH       = LINE_DEPTH_DEF;
    localparam int PHASES      = 8;
    localparam int PHASE_REQS  = 180;
    localparam int HOLD_LEN    = 300;
    localparam int STALL_LIMIT = 4000;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [BYTE_W-1:0]     cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic [FUNC_W-1:0]     s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tlast;

    int               pending;
    int               fail_count;
    logic [DEPTH-1:0] written;

    int          send_idle_pct = 0;
    int          stall_pct     = 0;
    int          hold_req      = 0;
    int          hold_seen     = 0;
    int          hold_left     = 0;
    int          quiet_cycles  = 0;
    int          sent          = 0;
    logic [7:0]  cur_end       = END_CHAR_RESET;
    logic [7:0]  cur_skip      = SKIP_CHAR_RESET;
    logic [7:0]  end_tab  [PHASES];
    logic [7:0]  skip_tab [PHASES];

    serial_line_assembler_top #(
        .LINE_DEPTH(DEPTH)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    sla_line_checker #(
        .DEPTH(DEPTH)
    ) u_line_check (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .pending   (pending),
        .written   (written),
        .fail_count(fail_count)
    );

    always #1 aclk = ~aclk;

    // Receiver: random stalls, or a long hold-off when one is requested.
    always @(posedge aclk) begin
        if (hold_seen != hold_req) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_LEN;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Watchdog: end the run when nothing moves for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic send_req(input func_t f, input logic [7:0] c, input logic err,
                            input logic [INDEX_W-1:0] idx);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= f;
        s_tdata  <= {1'b0, idx, err, c};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        sent++;
    endtask

    // Line content: anything but the end and skip characters.
    function automatic logic [7:0] line_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(255));
        while (c == cur_end || c == cur_skip);
        return c;
    endfunction

    // Only entries written since reset may be read back.
    task automatic send_read();
        int i;
        i = -1;
        for (int k = 0; k < 16 && i < 0; k++) begin
            i = $urandom_range(DEPTH - 1);
            if (!written[i])
                i = -1;
        end
        for (int k = 0; k < DEPTH && i < 0; k++)
            if (written[k])
                i = k;
        if (i < 0)
            send_req(FUNC_CLEAR, 8'($urandom_range(255)), 1'($urandom_range(1)),
                     6'($urandom_range(63)));
        else
            send_req(FUNC_READ, 8'($urandom_range(255)), 1'($urandom_range(1)), 6'(i));
    endtask

    task automatic send_char(input logic [7:0] c);
        send_req(FUNC_RX_BYTE, c, 1'b0, 6'($urandom_range(63)));
    endtask

    task automatic send_noise();
        int pick;
        logic [7:0] c;
        pick = $urandom_range(99);
        case ($urandom_range(3))
            0:       c = cur_end;
            1:       c = cur_skip;
            default: c = 8'($urandom_range(255));
        endcase
        if (pick < 60)
            send_req(FUNC_RX_BYTE, c, ($urandom_range(3) == 0), 6'($urandom_range(63)));
        else if (pick < 72)
            send_req(FUNC_RELEASE, c, 1'($urandom_range(1)), 6'($urandom_range(63)));
        else if (pick < 84)
            send_req(FUNC_CLEAR, c, 1'($urandom_range(1)), 6'($urandom_range(63)));
        else
            send_read();
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic load_chars(input logic [7:0] e, input logic [7:0] s);
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_END_CHAR;
        cfg_wdata <= e;
        @(posedge aclk);
        cfg_addr  <= CFG_SKIP_CHAR;
        cfg_wdata <= s;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        cur_end  = e;
        cur_skip = s;
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            0: begin send_idle_pct = 0;  stall_pct <= 0;  end
            1: begin send_idle_pct = 64; stall_pct <= 0;  end
            2: begin send_idle_pct = 0;  stall_pct <= 64; end
            default: begin send_idle_pct = 7; stall_pct <= 7; end
        endcase
    endtask

    task automatic run_directed();
        send_char(8'h00);
        send_char(8'hff);
        send_req(FUNC_RX_BYTE, 8'h41, 1'b1, 6'h3f);     // error byte: dropped
        send_char(cur_skip);                             // ignored
        send_char(8'h5a);
        send_char(cur_end);                              // completes the line
        send_req(FUNC_READ, 8'h00, 1'b0, 6'd0);
        send_req(FUNC_READ, 8'hff, 1'b1, 6'd1);
        send_req(FUNC_READ, 8'h00, 1'b0, 6'd2);
        send_req(FUNC_READ, 8'h00, 1'b0, 6'd3);          // terminator
        send_char(8'h33);                                // rejected: line held
        send_req(FUNC_RX_BYTE, 8'h34, 1'b1, 6'd0);       // error byte while rejecting
        send_char(8'h35);
        send_char(cur_end);                              // re-arm
        send_req(FUNC_CLEAR, 8'hff, 1'b1, 6'h3f);
        send_char(8'h7e);
        send_req(FUNC_RELEASE, 8'hff, 1'b1, 6'h3f);
        send_req(FUNC_CLEAR, 8'h00, 1'b0, 6'h00);
        send_req(FUNC_READ, 8'hff, 1'b1, 6'd0);
    endtask

    // End any line, then send more characters than the store holds so the reject count wraps.
    task automatic flood_rejects();
        send_char(cur_end);
        repeat (DEPTH + 258) send_char(line_char());
        send_char(cur_end);
    endtask

    task automatic run_random(input int count);
        int stop;
        int kind;
        int n;
        stop = sent + count;
        while (sent < stop) begin
            kind = $urandom_range(99);
            if (kind < 55) begin
                if ($urandom_range(99) < 60)
                    send_req(FUNC_RELEASE, 8'($urandom_range(255)), 1'($urandom_range(1)),
                             6'($urandom_range(63)));
                n = ($urandom_range(14) == 0) ? $urandom_range(DEPTH - 4, DEPTH + 6)
                                              : $urandom_range(12);
                repeat (n) send_char(line_char());
                send_char(cur_end);
                repeat ($urandom_range(1, 3)) send_read();
                if ($urandom_range(1))
                    send_req(FUNC_CLEAR, 8'($urandom_range(255)), 1'($urandom_range(1)),
                             6'($urandom_range(63)));
            end else if (kind < 85) begin
                repeat ($urandom_range(1, 6)) send_noise();
            end else begin
                // broken line: cut short by an error byte, a stray request or a release
                repeat ($urandom_range(1, 10)) send_char(line_char());
                send_req(FUNC_RX_BYTE, line_char(), 1'b1, 6'($urandom_range(63)));
                send_noise();
                repeat ($urandom_range(0, 4)) send_char(line_char());
            end
        end
    endtask

    initial begin
        end_tab  = '{8'h0d, 8'h00, 8'hff, 8'h7f, 8'h00, 8'h00, 8'h0a, 8'h00};
        skip_tab = '{8'h0a, 8'hff, 8'h00, 8'h7f, 8'h00, 8'h00, 8'h0d, 8'h00};
        for (int p = 4; p < PHASES; p++) begin
            if (p != 6) begin
                end_tab[p]  = 8'($urandom_range(255));
                skip_tab[p] = 8'($urandom_range(255));
            end
        end

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int p = 0; p < PHASES; p++) begin
            load_chars(end_tab[p], skip_tab[p]);
            set_idling(p % 4);
            if (p == 0) begin
                run_directed();
                hold_req <= hold_req + 1;
            end
            if (p == 2)
                flood_rejects();
            run_random(PHASE_REQS);
            drain_results();
        end

        repeat (8) @(posedge aclk);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
